>>> design/wdt_pkg.sv
`default_nettype none

package wdt_pkg;

  // Default width of the down counter and its reload value
  localparam int unsigned CountWidth = 16;

  localparam int unsigned DataWidth  = 16;
  localparam int unsigned PreWidth   = 8;
  localparam int unsigned DivWidth   = 7;

  // Command codes
  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdWrite = 2'd1,
    CmdRead  = 2'd2
  } wdt_cmd_e;

  // Register addresses
  localparam logic RegCtl   = 1'b0;
  localparam logic RegCount = 1'b1;

  // Control register fields
  localparam int unsigned CtlPreLsb = 8;
  localparam int unsigned CtlEnBit  = 5;
  localparam int unsigned CtlDivLsb = 3;
  localparam int unsigned CtlIrqBit = 2;
  localparam int unsigned CtlRstBit = 0;

  // One input item
  typedef struct packed {
    logic [1:0]           command;
    logic                 reg_select;
    logic [DataWidth-1:0] write_data;
  } wdt_item_t;

  // One result item
  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq_pulse;
    logic                 reset_pulse;
  } wdt_result_t;

  // Controls from the register block to the prescaler chain
  typedef struct packed {
    logic                step;
    logic [PreWidth-1:0] pre_limit;
    logic [1:0]          div_sel;
  } wdt_presc_ctrl_t;

  // Terminal count of the fixed divider, which divides the prescaler wraps by 16, 32, 64 or 128
  function automatic logic [DivWidth-1:0] div_limit(input logic [1:0] sel);
    logic [DivWidth-1:0] lim;
    unique case (sel)
      2'd0:    lim = 7'd15;
      2'd1:    lim = 7'd31;
      2'd2:    lim = 7'd63;
      default: lim = 7'd127;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

>>> design/wdt_in_if.sv
`default_nettype none

interface wdt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        reg_select;
  logic [15:0] write_data;

  modport source (output valid, output command, output reg_select, output write_data,
                  input ready);
  modport sink   (input valid, input command, input reg_select, input write_data,
                  output ready);
endinterface

`default_nettype wire

>>> design/wdt_out_if.sv
`default_nettype none

interface wdt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq_pulse;
  logic        reset_pulse;

  modport source (output valid, output read_data, output irq_pulse, output reset_pulse,
                  input ready);
  modport sink   (input valid, input read_data, input irq_pulse, input reset_pulse,
                  output ready);
endinterface

`default_nettype wire

>>> design/wdt_prescaler.sv
`default_nettype none

module wdt_prescaler (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wdt_pkg::wdt_presc_ctrl_t ctrl_i,
  output logic                     evt_o
);

  logic [wdt_pkg::PreWidth-1:0] pre_q, pre_d;
  logic [wdt_pkg::DivWidth-1:0] div_q, div_d;
  logic [wdt_pkg::DivWidth-1:0] div_lim;
  logic                         pre_wrap;
  logic                         div_wrap;

  assign div_lim = wdt_pkg::div_limit(ctrl_i.div_sel);

  // Prescaler wraps at its limit (or above, after the limit was lowered)
  assign pre_wrap = (pre_q >= ctrl_i.pre_limit);
  assign div_wrap = (div_q >= div_lim);

  always_comb begin
    pre_d = pre_q;
    div_d = div_q;
    evt_o = 1'b0;
    if (ctrl_i.step) begin
      if (pre_wrap) begin
        pre_d = '0;
        if (div_wrap) begin
          div_d = '0;
          evt_o = 1'b1;
        end else begin
          div_d = div_q + wdt_pkg::DivWidth'(1);
        end
      end else begin
        pre_d = pre_q + wdt_pkg::PreWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      div_q <= '0;
    end else begin
      pre_q <= pre_d;
      div_q <= div_d;
    end
  end

endmodule

`default_nettype wire

>>> design/wdt_timer.sv
`default_nettype none

module wdt_timer #(
  parameter int unsigned CountWidth = wdt_pkg::CountWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  wdt_pkg::wdt_item_t   item_i,
  output wdt_pkg::wdt_result_t result_o
);

  logic [wdt_pkg::DataWidth-1:0] ctl_q, ctl_d;
  logic [CountWidth-1:0]         count_q, count_d;
  logic [CountWidth-1:0]         reload_q, reload_d;
  logic [CountWidth-1:0]         wdata_cw;
  logic                          is_tick;
  logic                          tmr_evt;
  logic                          expired;
  wdt_pkg::wdt_presc_ctrl_t      presc_ctrl;

  assign is_tick  = (item_i.command == wdt_pkg::CmdTick);
  assign wdata_cw = CountWidth'(item_i.write_data);

  // Prescaler chain advances on ticks while enabled
  assign presc_ctrl.step      = fire_i && is_tick && ctl_q[wdt_pkg::CtlEnBit];
  assign presc_ctrl.pre_limit = ctl_q[wdt_pkg::CtlPreLsb +: wdt_pkg::PreWidth];
  assign presc_ctrl.div_sel   = ctl_q[wdt_pkg::CtlDivLsb +: 2];

  wdt_prescaler u_presc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (presc_ctrl),
    .evt_o  (tmr_evt)
  );

  // A count of one or zero runs out on the next event
  assign expired = tmr_evt && (count_q <= CountWidth'(1));

  // Register updates and result
  always_comb begin
    ctl_d    = ctl_q;
    count_d  = count_q;
    reload_d = reload_q;
    result_o = '0;
    unique case (item_i.command)
      wdt_pkg::CmdTick: begin
        if (tmr_evt) begin
          count_d = expired ? reload_q : count_q - CountWidth'(1);
        end
        result_o.irq_pulse   = expired && ctl_q[wdt_pkg::CtlIrqBit];
        result_o.reset_pulse = expired && ctl_q[wdt_pkg::CtlRstBit];
      end
      wdt_pkg::CmdWrite: begin
        if (item_i.reg_select == wdt_pkg::RegCtl) begin
          ctl_d = item_i.write_data;
        end else begin
          count_d  = wdata_cw;
          reload_d = wdata_cw;
        end
      end
      wdt_pkg::CmdRead: begin
        result_o.read_data = (item_i.reg_select == wdt_pkg::RegCtl) ? ctl_q
                           : wdt_pkg::DataWidth'(count_q);
      end
      default: ; // unused command: no effect, zero result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      count_q  <= '1;
      reload_q <= '1;
    end else if (fire_i) begin
      ctl_q    <= ctl_d;
      count_q  <= count_d;
      reload_q <= reload_d;
    end
  end

endmodule

`default_nettype wire

>>> design/watchdog_timer_prescaled_core.sv
// An accepted item passes through the input register and then the result register, where its result shows valid.
// Throughput: one item per cycle while the output is ready; the register update sets this figure.
// The input stage takes a new item while a finished result waits to be taken only if the input stage is empty.
// Reset (rst_ni low, asynchronous): timer disabled, count and reload all ones,
// prescaler and divider counters zero, both pipeline stages empty.
`default_nettype none

module watchdog_timer_prescaled_core #(
  parameter int unsigned CountWidth = wdt_pkg::CountWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wdt_in_if.sink    in_i,
  wdt_out_if.source out_o
);

  logic                 in_vld_q;
  wdt_pkg::wdt_item_t   in_item_q;
  logic                 out_vld_q;
  wdt_pkg::wdt_result_t out_res_q;
  wdt_pkg::wdt_result_t exe_res;
  logic                 out_free;
  logic                 fire;
  logic                 in_acc;

  // Stage handshakes
  assign out_free   = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || fire;
  assign in_acc     = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_item_q.command    <= in_i.command;
      in_item_q.reg_select <= in_i.reg_select;
      in_item_q.write_data <= in_i.write_data;
    end
  end

  // Register block and timer
  wdt_timer #(
    .CountWidth (CountWidth)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .result_o (exe_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= exe_res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.read_data   = out_res_q.read_data;
  assign out_o.irq_pulse   = out_res_q.irq_pulse;
  assign out_o.reset_pulse = out_res_q.reset_pulse;

`ifndef SYNTHESIS
  // A pulse comes only from a tick, read data only from a read
  a_pulse_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_res_q.irq_pulse || out_res_q.reset_pulse)
      |-> (out_res_q.read_data == '0))
    else $error("pulse with non-zero read data");

  // A waiting input item is kept until it executes
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q)
    else $error("input item dropped");

  // An executed item always lands in the result register
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("result lost");
`endif

endmodule

`default_nettype wire
